### rtl/imaenc_pkg.sv
// ----------------------------------------------------------------------------
// imaenc_pkg
// shared types, constants and tables of the ima adpcm encoder
// ----------------------------------------------------------------------------
`default_nettype none

package imaenc_pkg;

    localparam logic [1:0] FMT_U8    = 2'd0;
    localparam logic [1:0] FMT_S16   = 2'd1;
    localparam logic [1:0] FMT_S32HI = 2'd2;

    localparam logic [6:0] IDX_MAX = 7'd88;

    localparam logic signed [17:0] PRED_MAX = 18'sd32767;
    localparam logic signed [17:0] PRED_MIN = -18'sd32768;

    localparam logic [15:0] U8_BIAS = 16'd128;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               start;
    } t_entry;

    function automatic logic [14:0] step_size(input logic [6:0] idx);
        logic [14:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] a;
        case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### rtl/imaenc_front.sv
// ----------------------------------------------------------------------------
// imaenc_front
// input side: holds the format register and widens each sample to 16 bits
// ----------------------------------------------------------------------------
`default_nettype none

module imaenc_front
    import imaenc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_sample_word,
    input  wire logic        i_start_of_block,
    input  wire logic        i_queue_full,
    output logic             o_stall,
    output logic             o_push,
    output t_entry           o_entry
);

    logic [1:0] r_format;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_S16;
        end else if (i_cfg_we) begin
            r_format <= i_cfg_data;
        end
    end

    always_comb begin
        case (r_format)
            FMT_U8:  o_entry.sample = $signed({8'd0, i_sample_word[7:0]} - U8_BIAS);
            FMT_S16: o_entry.sample = $signed(i_sample_word[15:0]);
            default: o_entry.sample = $signed(i_sample_word[31:16]);
        endcase
        o_entry.start = i_start_of_block;
    end

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

endmodule

`default_nettype wire

### rtl/imaenc_queue.sv
// ----------------------------------------------------------------------------
// imaenc_queue
// short first-in first-out queue between the front and the coder
// ----------------------------------------------------------------------------
`default_nettype none

module imaenc_queue
    import imaenc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_wdata,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_entry      o_rdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rptr];
    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);

endmodule

`default_nettype wire

### rtl/imaenc_core.sv
// ----------------------------------------------------------------------------
// imaenc_core
// coder: adpcm quantizer, predictor and step index, nibble pairing, output word
// ----------------------------------------------------------------------------
`default_nettype none

module imaenc_core
    import imaenc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_empty,
    input  wire t_entry i_entry,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_stall,
    output logic [7:0]  o_packed_byte
);

    logic signed [15:0] r_pred;
    logic [6:0]         r_idx;
    logic [3:0]         r_held;
    logic               r_phase;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;

    logic signed [15:0] pred_cur;
    logic [6:0]         idx_cur;
    logic [3:0]         held_cur;
    logic               phase_cur;

    logic [16:0]        step0, step1, step2;
    logic signed [16:0] diff_s;
    logic [16:0]        d0, d1, d2;
    logic [16:0]        vp0, vp1, vp2, vp3;
    logic [2:0]         mag;
    logic               sign;
    logic [3:0]         code;
    logic signed [17:0] pred_sum;
    logic signed [15:0] n_pred;
    logic signed [7:0]  idx_sum;
    logic [6:0]         n_idx;
    logic               out_free;
    logic               emit;

    always_comb begin
        pred_cur  = i_entry.start ? '0 : r_pred;
        idx_cur   = i_entry.start ? '0 : r_idx;
        held_cur  = i_entry.start ? '0 : r_held;
        phase_cur = i_entry.start ? 1'b0 : r_phase;

        step0  = {2'b00, step_size(idx_cur)};
        step1  = step0 >> 1;
        step2  = step0 >> 2;
        diff_s = 17'(i_entry.sample) - 17'(pred_cur);
        sign   = diff_s[16];
        d0     = sign ? 17'(-diff_s) : 17'(diff_s);

        vp0 = step0 >> 3;
        mag[2] = (d0 >= step0);
        d1  = mag[2] ? d0 - step0 : d0;
        vp1 = mag[2] ? vp0 + step0 : vp0;
        mag[1] = (d1 >= step1);
        d2  = mag[1] ? d1 - step1 : d1;
        vp2 = mag[1] ? vp1 + step1 : vp1;
        mag[0] = (d2 >= step2);
        vp3 = mag[0] ? vp2 + step2 : vp2;

        pred_sum = sign ? 18'(pred_cur) - $signed({1'b0, vp3})
                        : 18'(pred_cur) + $signed({1'b0, vp3});
        if (pred_sum > PRED_MAX) begin
            n_pred = 16'(PRED_MAX);
        end else if (pred_sum < PRED_MIN) begin
            n_pred = 16'(PRED_MIN);
        end else begin
            n_pred = 16'(pred_sum);
        end

        idx_sum = $signed({1'b0, idx_cur}) + 8'(index_adjust(mag));
        if (idx_sum < 0) begin
            n_idx = '0;
        end else if (idx_sum > $signed({1'b0, IDX_MAX})) begin
            n_idx = IDX_MAX;
        end else begin
            n_idx = 7'(idx_sum);
        end

        code     = {sign, mag};
        out_free = !r_out_valid || !i_stall;
        emit     = phase_cur;
        o_pop    = !i_empty && (!emit || out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred      <= '0;
            r_idx       <= '0;
            r_held      <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pred  <= n_pred;
                r_idx   <= n_idx;
                r_held  <= code;
                r_phase <= !phase_cur;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_byte <= {held_cur, code};
        end
    end

    assign o_valid       = r_out_valid;
    assign o_packed_byte = r_out_byte;

endmodule

`default_nettype wire

### rtl/ima_adpcm_encoder.sv
// ----------------------------------------------------------------------------
// ima_adpcm_encoder
// pcm to 4-bit ima adpcm encoder, two codes packed per output byte
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall carry one sample word and a start-of-block
//   flag; a word is taken at a clock edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall carry one packed byte, earlier code in the
//   high nibble; a byte is taken with o_valid high and i_stall low.
// i_cfg_we / i_cfg_data write the sample format; write only while idle.
// throughput: one sample per cycle while o_stall is low; a byte comes out
//   for every second sample. a byte's second sample is written into the
//   queue when taken, then moves through the coder into the output register;
//   a stalled output can hold it in the queue. the coder's predictor / step
//   index loop is combinational and is registered as each sample is popped.
// o_stall rises only when the QUEUE_DEPTH entry queue is full; a stalled
//   output holds its byte while the coder keeps taking first-of-pair samples.
// reset: format returns to 16-bit signed, queue empties, predictor, step
//   index and pairing clear, and no byte is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module ima_adpcm_encoder
    import imaenc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_sample_word,
    input  wire logic        i_start_of_block,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_packed_byte
);

    t_entry front_entry;
    t_entry queue_entry;
    logic   push;
    logic   pop;
    logic   queue_full;
    logic   queue_empty;

    imaenc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .i_sample_word    (i_sample_word),
        .i_start_of_block (i_start_of_block),
        .i_queue_full     (queue_full),
        .o_stall          (o_stall),
        .o_push           (push),
        .o_entry          (front_entry)
    );

    imaenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_entry),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_rdata (queue_entry)
    );

    imaenc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (queue_empty),
        .i_entry       (queue_entry),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_byte (o_packed_byte)
    );

endmodule

`default_nettype wire
